/* rtl/core/lmgs_pkg.sv */
`default_nettype none

package lmgs_pkg;

  // Default geometry
  localparam int LinesDef   = 8;
  localparam int ColumnsDef = 8;
  localparam int LevelsDef  = 16;

  // Fixed field widths
  localparam int RowW     = 3;
  localparam int ColW     = 3;
  localparam int PixW     = 12;
  localparam int NibW     = 4;
  localparam int OutW     = 24;
  localparam int LineOnW  = 3;

  // Red threshold is pulled down by this much at higher levels
  localparam int RedOffset = 4;

  localparam logic KindWrite = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_TAIL,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic wr_en;       // store the pixel on the input ports
    logic tick_start;  // restart the column sweep
    logic rd_en;       // read the next pixel of the scan line
    logic emit;        // load the result and advance line and level
  } cmd_t;

  typedef struct packed {
    logic col_last;    // sweep is at the last column
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/lmgs_ctrl.sv */
`default_nettype none

module lmgs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          kind_i,
  input  lmgs_pkg::stat_t    stat_i,
  output lmgs_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  import lmgs_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KindTick)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.col_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: state_d = S_EMIT;
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o           = 1'b0;
        cmd_o.wr_en      = accept && (kind_i == KindWrite);
        cmd_o.tick_start = accept && (kind_i == KindTick);
      end
      S_READ: cmd_o.rd_en = 1'b1;
      S_TAIL: cmd_o = '0;
      S_EMIT: cmd_o.emit = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_tick_enters_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindTick)) |=> (state_q == S_READ))
    else $error("tick transfer did not start the column sweep");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_READ) && stat_i.col_last) |=> (state_q == S_TAIL))
    else $error("sweep did not stop at the last column");

  a_tail_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL) |=> (state_q == S_EMIT))
    else $error("last pixel not followed by result load");

endmodule

`default_nettype wire

/* rtl/core/lmgs_datapath.sv */
`default_nettype none

module lmgs_datapath #(
  parameter int LINES   = lmgs_pkg::LinesDef,
  parameter int COLUMNS = lmgs_pkg::ColumnsDef,
  parameter int LEVELS  = lmgs_pkg::LevelsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  lmgs_pkg::cmd_t                 cmd_i,
  output lmgs_pkg::stat_t                stat_o,
  input  wire logic [lmgs_pkg::RowW-1:0] pixel_row_i,
  input  wire logic [lmgs_pkg::ColW-1:0] pixel_column_i,
  input  wire logic [lmgs_pkg::PixW-1:0] pixel_value_i,
  output logic                           done_o,
  output logic [lmgs_pkg::OutW-1:0]      column_bits_o,
  output logic [lmgs_pkg::LineOnW-1:0]   line_on_o
);
  import lmgs_pkg::*;

  localparam int LW    = $clog2(LINES);
  localparam int CW    = $clog2(COLUMNS);
  localparam int VW    = $clog2(LEVELS);
  localparam int AW    = LW + CW;
  localparam int Depth = 2 ** AW;
  localparam int AccW  = 3 * COLUMNS;

  logic [PixW-1:0]    mem_q [Depth];
  logic [Depth-1:0]   vld_q;
  logic [PixW-1:0]    rd_data_q;
  logic               rd_vld_q;
  logic               rd_pend_q;

  logic [LW-1:0]      line_q;
  logic [VW-1:0]      level_q;
  logic [CW-1:0]      col_q;
  logic [COLUMNS-1:0] green_q, red_q, blue_q;

  logic               done_q;
  logic [OutW-1:0]    column_bits_q;
  logic [LineOnW-1:0] line_on_q;

  logic               wr_hit;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [PixW-1:0]    pixel;
  logic [NibW-1:0]    level_n, red_thr;
  logic               line_last;
  logic [AccW-1:0]    acc;

  // Rows or columns outside the matrix are dropped
  assign wr_hit  = cmd_i.wr_en && (32'(pixel_row_i) < LINES) && (32'(pixel_column_i) < COLUMNS);
  assign wr_addr = {LW'(pixel_row_i), CW'(pixel_column_i)};
  assign rd_addr = {line_q, col_q};

  assign stat_o.col_last = (col_q == CW'(COLUMNS - 1));
  assign line_last       = (line_q == LW'(LINES - 1));

  // Never-written entries read as zero
  assign pixel   = rd_vld_q ? rd_data_q : '0;
  assign level_n = NibW'(level_q);
  assign red_thr = (level_n < NibW'(RedOffset)) ? level_n : level_n - NibW'(RedOffset);
  assign acc     = {green_q, red_q, blue_q};

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_addr] <= pixel_value_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
    if (rd_pend_q) begin
      green_q <= {green_q[COLUMNS-2:0], pixel[11:8] > level_n};
      red_q   <= {red_q[COLUMNS-2:0],   pixel[7:4]  > red_thr};
      blue_q  <= {blue_q[COLUMNS-2:0],  pixel[3:0]  > level_n};
    end
    if (cmd_i.emit) begin
      column_bits_q <= OutW'(acc);
      line_on_q     <= LineOnW'(line_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_pend_q <= 1'b0;
      col_q     <= '0;
      line_q    <= '0;
      level_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
      done_q    <= cmd_i.emit;
      if (wr_hit) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.tick_start) begin
        col_q <= '0;
      end else if (cmd_i.rd_en && !stat_o.col_last) begin
        col_q <= col_q + CW'(1);
      end
      // Advance the line; the level steps once per frame
      if (cmd_i.emit) begin
        if (line_last) begin
          line_q <= '0;
          if (level_q == VW'(LEVELS - 1)) begin
            level_q <= '0;
          end else begin
            level_q <= level_q + VW'(1);
          end
        end else begin
          line_q <= line_q + LW'(1);
        end
      end
    end
  end

  assign done_o        = done_q;
  assign column_bits_o = column_bits_q;
  assign line_on_o     = line_on_q;

  a_no_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.rd_en && cmd_i.wr_en))
    else $error("pixel write during line sweep");

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && line_last) |=> (line_q == '0))
    else $error("scan line did not wrap");

  a_level_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit && line_last) |=> $stable(level_q))
    else $error("level moved without a frame wrap");

endmodule

`default_nettype wire

/* rtl/core/led_matrix_gray_scan.sv */
// Pixel write: taken while idle, no result, busy stays low.
// Scan tick: the frame store is read one pixel per cycle across the columns, then the
// result is loaded and strobed on done_o; busy is high from the transfer through the load.
// done_o is high for one cycle only; the receiver cannot stall it.
// Reset clears the frame store (per-pixel valid flags), scan line and level at once.
`default_nettype none

module led_matrix_gray_scan #(
  parameter int LINES   = lmgs_pkg::LinesDef,
  parameter int COLUMNS = lmgs_pkg::ColumnsDef,
  parameter int LEVELS  = lmgs_pkg::LevelsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         kind_i,
  input  wire logic [lmgs_pkg::RowW-1:0]    pixel_row_i,
  input  wire logic [lmgs_pkg::ColW-1:0]    pixel_column_i,
  input  wire logic [lmgs_pkg::PixW-1:0]    pixel_value_i,
  output logic                              done_o,
  output logic [lmgs_pkg::OutW-1:0]         column_bits_o,
  output logic [lmgs_pkg::LineOnW-1:0]      line_on_o
);
  import lmgs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lmgs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (kind_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  lmgs_datapath #(
    .LINES   (LINES),
    .COLUMNS (COLUMNS),
    .LEVELS  (LEVELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .pixel_value_i  (pixel_value_i),
    .done_o         (done_o),
    .column_bits_o  (column_bits_o),
    .line_on_o      (line_on_o)
  );

endmodule

`default_nettype wire

/* test/gray_scan_checker.sv */
`timescale 1ns / 1ps

module gray_scan_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic                         kind_i,
  input  wire logic [lmgs_pkg::RowW-1:0]    pixel_row_i,
  input  wire logic [lmgs_pkg::ColW-1:0]    pixel_column_i,
  input  wire logic [lmgs_pkg::PixW-1:0]    pixel_value_i,
  input  wire logic                         done_o,
  input  wire logic [lmgs_pkg::OutW-1:0]    column_bits_o,
  input  wire logic [lmgs_pkg::LineOnW-1:0] line_on_o,
  output int                                fail_count,
  output int                                open_count
);
  import lmgs_pkg::*;

  typedef struct packed {
    logic [OutW-1:0]    column_bits;
    logic [LineOnW-1:0] line_on;
  } scan_out_t;

  logic [PixW-1:0] pixel_mem [LinesDef][ColumnsDef];
  logic [2:0]      scan_line_q;
  logic [3:0]      gray_level_q;
  scan_out_t       expected_scans[$];

  // Build the column bits for the current line; advance line and level.
  function automatic scan_out_t predict_scan();
    scan_out_t       res;
    logic [3:0]      red_thr;
    logic [PixW-1:0] pix;
    res = '0;
    red_thr = (gray_level_q < 4'(RedOffset)) ? gray_level_q : gray_level_q - 4'(RedOffset);
    for (int c = 0; c < ColumnsDef; c++) begin
      pix = pixel_mem[scan_line_q][c];
      res.column_bits[23 - c] = pix[11:8] > gray_level_q;
      res.column_bits[15 - c] = pix[7:4] > red_thr;
      res.column_bits[7 - c]  = pix[3:0] > gray_level_q;
    end
    res.line_on = scan_line_q;
    if (scan_line_q == LinesDef - 1) begin
      scan_line_q = '0;
      gray_level_q = (gray_level_q == LevelsDef - 1) ? '0 : gray_level_q + 1'b1;
    end else begin
      scan_line_q = scan_line_q + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_out_t want;
    if (!rst_ni) begin
      for (int r = 0; r < LinesDef; r++) begin
        for (int c = 0; c < ColumnsDef; c++) begin
          pixel_mem[r][c] = '0;
        end
      end
      scan_line_q = '0;
      gray_level_q = '0;
      expected_scans.delete();
      fail_count = 0;
      open_count = 0;
    end else begin
      // retire the oldest expectation before taking a new transfer
      if (done_o) begin
        if (expected_scans.size() == 0) begin
          $error("unexpected result: column_bits %h line_on %0d", column_bits_o, line_on_o);
          fail_count = fail_count + 1;
        end else begin
          want = expected_scans.pop_front();
          if (column_bits_o !== want.column_bits) begin
            $error("column_bits: expected %h, actual %h", want.column_bits, column_bits_o);
            fail_count = fail_count + 1;
          end
          if (line_on_o !== want.line_on) begin
            $error("line_on: expected %0d, actual %0d", want.line_on, line_on_o);
            fail_count = fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (kind_i == KindTick) begin
          expected_scans.push_back(predict_scan());
        end else begin
          pixel_mem[pixel_row_i][pixel_column_i] = pixel_value_i;
        end
      end
      open_count = expected_scans.size();
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lmgs_pkg::*;

  localparam int RandomItems = 500;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               kind_i;
  logic [RowW-1:0]    pixel_row_i;
  logic [ColW-1:0]    pixel_column_i;
  logic [PixW-1:0]    pixel_value_i;
  logic               done_o;
  logic [OutW-1:0]    column_bits_o;
  logic [LineOnW-1:0] line_on_o;
  int                 fail_count;
  int                 open_count;
  int                 cycle_count = 0;

  led_matrix_gray_scan u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .pixel_value_i  (pixel_value_i),
    .done_o         (done_o),
    .column_bits_o  (column_bits_o),
    .line_on_o      (line_on_o)
  );

  gray_scan_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_column_i (pixel_column_i),
    .pixel_value_i  (pixel_value_i),
    .done_o         (done_o),
    .column_bits_o  (column_bits_o),
    .line_on_o      (line_on_o),
    .fail_count     (fail_count),
    .open_count     (open_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(input logic kind, input logic [RowW-1:0] row,
                           input logic [ColW-1:0] col, input logic [PixW-1:0] value);
    start          <= 1'b1;
    kind_i         <= kind;
    pixel_row_i    <= row;
    pixel_column_i <= col;
    pixel_value_i  <= value;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_item(KindTick, RowW'($urandom_range(7)), ColW'($urandom_range(7)),
              PixW'($urandom_range(4095)));
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {NibW'($urandom_range(15)), 8'h00};
      default: return PixW'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic quiet;
    start          = 1'b0;
    kind_i         = KindWrite;
    pixel_row_i    = '0;
    pixel_column_i = '0;
    pixel_value_i  = '0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, single colors and nibbles near the red offset
    send_item(KindWrite, 3'd0, 3'd0, 12'hFFF);
    send_item(KindWrite, 3'd0, 3'd7, 12'h000);
    send_item(KindWrite, 3'd0, 3'd1, 12'h0F0);
    send_item(KindWrite, 3'd0, 3'd2, 12'h050);
    send_item(KindWrite, 3'd0, 3'd3, 12'h100);
    send_item(KindWrite, 3'd0, 3'd4, 12'h001);
    send_item(KindWrite, 3'd7, 3'd0, 12'hF0F);
    send_item(KindWrite, 3'd7, 3'd7, 12'h8C4);
    // tick with junk on the pixel fields: they must be ignored
    send_item(KindTick, 3'd7, 3'd7, 12'hFFF);
    for (int i = 0; i < 7; i++) send_tick();
    // level is now 1: zero and low nibbles go dark
    send_item(KindWrite, 3'd0, 3'd0, 12'h000);
    send_item(KindTick, 3'd0, 3'd0, 12'h000);
    hold_off(2);
    for (int i = 0; i < 7; i++) send_tick();

    for (int n = 0; n < RandomItems; n++) begin
      quiet = (n >= 200 && n < 300);
      if (!quiet && $urandom_range(99) < 28) hold_off($urandom_range(1, 4));
      if ($urandom_range(1)) send_tick();
      else send_item(KindWrite, RowW'($urandom_range(7)), ColW'($urandom_range(7)),
                     pick_pixel());
    end
    start <= 1'b0;

    wait (open_count == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
